@@ src/txc_pkg.sv @@
// ----------------------------------------------------------------------------
// txc_pkg
// Shared types, codes, constants and the control store of the text console
// character writer.
// ----------------------------------------------------------------------------
package txc_pkg;

  // default geometry
  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STOP_DEF = 8;

  localparam logic [7:0]  ATTR_RESET = 8'h07;
  localparam logic [15:0] RESET_CELL = 16'h0F20;
  localparam logic [7:0]  BLANK_CHAR = 8'h20;

  // operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // control characters
  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  typedef struct packed {
    logic       op;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } req_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
  } rsp_t;

  // microprogram steps
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISP,
    S_READ,
    S_PUT,
    S_TAB,
    S_TAB_END,
    S_BS,
    S_BS_BLANK,
    S_CR,
    S_LF,
    S_NEWLINE,
    S_SCROLL,
    S_SCROLL_END,
    S_DONE
  } step_t;

  // branch conditions
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_OUT_FREE,
    C_X_LAST,
    C_X_ZERO,
    C_TAB_END,
    C_Y_LAST,
    C_SWEEP_LAST,
    C_CLEAR_LAST,
    C_DISPATCH
  } cond_t;

  // cell store write source
  typedef enum logic [2:0] {
    W_NONE,
    W_CHAR,
    W_BLANK_CUR,
    W_SCROLL,
    W_CLEAR
  } wsel_t;

  typedef enum logic [1:0] {
    X_HOLD,
    X_INC,
    X_DEC,
    X_ZERO
  } xop_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ZERO,
    CELL_READ
  } cell_op_t;

  // request class used by the dispatch step
  typedef enum logic [2:0] {
    CL_READ,
    CL_NUL,
    CL_LF,
    CL_CR,
    CL_TAB,
    CL_BS,
    CL_PRINT
  } cls_t;

  typedef struct packed {
    cond_t    cond;
    step_t    tgt_t;
    step_t    tgt_f;
    wsel_t    wsel;
    xop_t     xop;
    logic     y_inc;
    logic     top_adv;
    logic     sweep_inc;
    cell_op_t cell_op;
    logic     accept;
    logic     load_out;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic x_last;
    logic x_zero;
    logic tab_end;
    logic y_last;
    logic sweep_last;
    logic clear_last;
  } flags_t;

  localparam ctl_t CTL_NOP = '{
    cond: C_ALWAYS, tgt_t: S_IDLE, tgt_f: S_IDLE, wsel: W_NONE, xop: X_HOLD,
    y_inc: 1'b0, top_adv: 1'b0, sweep_inc: 1'b0, cell_op: CELL_HOLD,
    accept: 1'b0, load_out: 1'b0
  };

  // control store: one word per step
  function automatic ctl_t micro_rom(input step_t s);
    ctl_t w;
    w = CTL_NOP;
    case (s)
      S_CLEAR: begin
        w.cond = C_CLEAR_LAST; w.tgt_t = S_IDLE; w.tgt_f = S_CLEAR;
        w.wsel = W_CLEAR; w.sweep_inc = 1'b1;
      end
      S_IDLE: begin
        w.cond = C_IN_VALID; w.tgt_t = S_DISP; w.tgt_f = S_IDLE;
        w.accept = 1'b1;
      end
      S_DISP: begin
        w.cond = C_DISPATCH; w.cell_op = CELL_ZERO;
      end
      S_READ: begin
        w.tgt_t = S_DONE; w.tgt_f = S_DONE; w.cell_op = CELL_READ;
      end
      S_PUT: begin
        w.cond = C_X_LAST; w.tgt_t = S_NEWLINE; w.tgt_f = S_DONE;
        w.wsel = W_CHAR; w.xop = X_INC;
      end
      S_TAB: begin
        w.cond = C_TAB_END; w.tgt_t = S_TAB_END; w.tgt_f = S_TAB;
        w.wsel = W_BLANK_CUR; w.xop = X_INC;
      end
      S_TAB_END: begin
        // column back at zero means the fill ran off the row end
        w.cond = C_X_ZERO; w.tgt_t = S_NEWLINE; w.tgt_f = S_DONE;
      end
      S_BS: begin
        w.tgt_t = S_BS_BLANK; w.tgt_f = S_BS_BLANK; w.xop = X_DEC;
      end
      S_BS_BLANK: begin
        w.tgt_t = S_DONE; w.tgt_f = S_DONE; w.wsel = W_BLANK_CUR;
      end
      S_CR: begin
        w.tgt_t = S_DONE; w.tgt_f = S_DONE; w.xop = X_ZERO;
      end
      S_LF: begin
        w.tgt_t = S_NEWLINE; w.tgt_f = S_NEWLINE; w.xop = X_ZERO;
      end
      S_NEWLINE: begin
        w.cond = C_Y_LAST; w.tgt_t = S_SCROLL; w.tgt_f = S_DONE;
        w.y_inc = 1'b1;
      end
      S_SCROLL: begin
        w.cond = C_SWEEP_LAST; w.tgt_t = S_SCROLL_END; w.tgt_f = S_SCROLL;
        w.wsel = W_SCROLL; w.sweep_inc = 1'b1;
      end
      S_SCROLL_END: begin
        w.tgt_t = S_DONE; w.tgt_f = S_DONE; w.top_adv = 1'b1;
      end
      S_DONE: begin
        w.cond = C_OUT_FREE; w.tgt_t = S_IDLE; w.tgt_f = S_DONE;
        w.load_out = 1'b1;
      end
      default: w = CTL_NOP;
    endcase
    return w;
  endfunction

  function automatic step_t dispatch(input cls_t c);
    step_t s;
    s = S_DONE;
    case (c)
      CL_READ:  s = S_READ;
      CL_NUL:   s = S_DONE;
      CL_LF:    s = S_LF;
      CL_CR:    s = S_CR;
      CL_TAB:   s = S_TAB;
      CL_BS:    s = S_BS;
      CL_PRINT: s = S_PUT;
      default:  s = S_DONE;
    endcase
    return s;
  endfunction

endpackage

@@ src/txc_seq.sv @@
// ----------------------------------------------------------------------------
// txc_seq
// Step counter and branch logic; looks up the control word of the current
// step in the control store.
// ----------------------------------------------------------------------------
module txc_seq
  import txc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  input  cls_t   cls,
  output ctl_t   ctl
);

  step_t step;
  step_t step_next;
  logic  hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_CLEAR;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    ctl = micro_rom(step);
    case (ctl.cond)
      C_ALWAYS:     hit = 1'b1;
      C_IN_VALID:   hit = flags.in_valid;
      C_OUT_FREE:   hit = flags.out_free;
      C_X_LAST:     hit = flags.x_last;
      C_X_ZERO:     hit = flags.x_zero;
      C_TAB_END:    hit = flags.tab_end;
      C_Y_LAST:     hit = flags.y_last;
      C_SWEEP_LAST: hit = flags.sweep_last;
      C_CLEAR_LAST: hit = flags.clear_last;
      default:      hit = 1'b1;
    endcase
    if (ctl.cond == C_DISPATCH) begin
      step_next = dispatch(cls);
    end else if (hit) begin
      step_next = ctl.tgt_t;
    end else begin
      step_next = ctl.tgt_f;
    end
  end

endmodule

@@ src/text_console_char_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_char_writer
// Character-cell text console: cell store, cursor and scroll, run by a
// microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_stall  | req_t (op, char_code, read_row, read_col)
//  rsp     | out | rsp_valid/rsp_stall  | rsp_t (cell_value, cursor_col, cursor_row)
//  cfg     | in  | cfg_we               | cfg_wdata (attribute byte)
//
//  Each item runs from the accept step through dispatch and its own steps to a
//  done step that loads the result once the output is free. A tab fills one
//  cell per step. A wrap adds the new-line step; a new line on the bottom row
//  adds a sweep that blanks the line. After reset a clearing pass writes the
//  reset cell to all ROWS * COLUMNS entries before the first request is taken.
//  A waiting result lets the next item run; that item holds in its last step.
// ----------------------------------------------------------------------------
module text_console_char_writer
  import txc_pkg::*;
#(
  parameter int COLUMNS  = COLUMNS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  localparam int XW    = $clog2(COLUMNS);
  localparam int YW    = $clog2(ROWS);
  localparam int PW    = $clog2(TAB_STOP);
  localparam int AW    = XW + YW;
  localparam int DEPTH = ROWS * (2 ** XW);

  localparam logic [XW-1:0] X_MAX = XW'(COLUMNS - 1);
  localparam logic [YW-1:0] Y_MAX = YW'(ROWS - 1);
  localparam logic [PW-1:0] P_MAX = PW'(TAB_STOP - 1);

  ctl_t   ctl;
  flags_t flags;
  cls_t   cls;

  logic [7:0]    attr;
  req_t          req_q;
  logic [XW-1:0] x;
  logic [PW-1:0] phase;
  logic [YW-1:0] y;
  logic [YW-1:0] top;
  logic [XW-1:0] sweep;
  logic [YW-1:0] clr_row;
  logic [15:0]   cell_word;

  logic [15:0]   mem [DEPTH];
  logic [15:0]   rdata;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [15:0]   wdata;

  logic [YW-1:0] cur_prow;
  logic [YW-1:0] rd_prow;
  logic          rd_in_range;
  logic          accept;
  logic          out_free;
  logic          load_out;

  // map a screen row to its store row, the store being rotated by top
  function automatic logic [YW-1:0] phys_row(input logic [YW-1:0] r,
                                             input logic [YW-1:0] t);
    logic [YW:0] sum;
    sum = {1'b0, r} + {1'b0, t};
    if (sum >= (YW + 1)'(ROWS)) begin
      sum = sum - (YW + 1)'(ROWS);
    end
    return sum[YW-1:0];
  endfunction

  txc_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .cls   (cls),
    .ctl   (ctl)
  );

  assign req_stall = !ctl.accept;
  assign accept    = req_valid && ctl.accept;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign load_out  = ctl.load_out && out_free;

  always_comb begin
    flags.in_valid   = req_valid;
    flags.out_free   = out_free;
    flags.x_last     = (x == X_MAX);
    flags.x_zero     = (x == '0);
    flags.tab_end    = (phase == P_MAX) || (x == X_MAX);
    flags.y_last     = (y == Y_MAX);
    flags.sweep_last = (sweep == X_MAX);
    flags.clear_last = (sweep == X_MAX) && (clr_row == Y_MAX);
  end

  always_comb begin
    if (req_q.op == OP_READ) begin
      cls = CL_READ;
    end else begin
      case (req_q.char_code)
        CH_NUL:  cls = CL_NUL;
        CH_LF:   cls = CL_LF;
        CH_CR:   cls = CL_CR;
        CH_TAB:  cls = CL_TAB;
        CH_BS:   cls = CL_BS;
        default: cls = CL_PRINT;
      endcase
    end
  end

  assign cur_prow    = phys_row(y, top);
  assign rd_prow     = phys_row(YW'(req_q.read_row), top);
  assign rd_in_range = (8'(req_q.read_row) < 8'(ROWS)) &&
                       (9'(req_q.read_col) < 9'(COLUMNS));
  assign raddr       = {rd_prow, XW'(req_q.read_col)};

  always_comb begin
    mem_we = 1'b1;
    waddr  = {cur_prow, x};
    wdata  = {attr, BLANK_CHAR};
    case (ctl.wsel)
      W_NONE:      mem_we = 1'b0;
      W_CHAR:      wdata  = {attr, req_q.char_code};
      W_BLANK_CUR: wdata  = {attr, BLANK_CHAR};
      W_SCROLL:    waddr  = {top, sweep};
      W_CLEAR: begin
        waddr = {clr_row, sweep};
        wdata = RESET_CELL;
      end
      default:     mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    case (ctl.cell_op)
      CELL_ZERO: cell_word <= '0;
      CELL_READ: cell_word <= rd_in_range ? rdata : 16'h0000;
      default:   cell_word <= cell_word;
    endcase
    if (load_out) begin
      rsp.cell_value <= cell_word;
      rsp.cursor_col <= 7'(x);
      rsp.cursor_row <= 5'(y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attr      <= ATTR_RESET;
      x         <= '0;
      phase     <= '0;
      y         <= '0;
      top       <= '0;
      sweep     <= '0;
      clr_row   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr <= cfg_wdata;
      end
      case (ctl.xop)
        X_INC: begin
          if (x == X_MAX) begin
            x     <= '0;
            phase <= '0;
          end else begin
            x     <= x + 1'b1;
            phase <= (phase == P_MAX) ? '0 : phase + 1'b1;
          end
        end
        X_DEC: begin
          // hold at column zero
          if (x != '0) begin
            x     <= x - 1'b1;
            phase <= (phase == '0) ? P_MAX : phase - 1'b1;
          end
        end
        X_ZERO: begin
          x     <= '0;
          phase <= '0;
        end
        default: ;
      endcase
      if (ctl.y_inc && (y != Y_MAX)) begin
        y <= y + 1'b1;
      end
      // the old top store row becomes the new bottom line
      if (ctl.top_adv) begin
        top <= (top == Y_MAX) ? '0 : top + 1'b1;
      end
      if (ctl.sweep_inc) begin
        sweep <= (sweep == X_MAX) ? '0 : sweep + 1'b1;
      end
      if ((ctl.wsel == W_CLEAR) && (sweep == X_MAX)) begin
        clr_row <= clr_row + 1'b1;
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ tb/sv/tb_text_console_char_writer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_char_writer
// Self-checking bench for the text console character writer. A directed run
// covers reads at and past the screen edges and every control character.
// Random phases follow, each with its own attribute byte. They mix text
// bursts that wrap, line feed runs that scroll, tabs, backspaces, reads and
// noise items. A local screen model predicts every response. Both channels
// idle at random but in one phase, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_text_console_char_writer;
  import txc_pkg::*;

  localparam int COLS        = COLUMNS_DEF;
  localparam int NROWS       = ROWS_DEF;
  localparam int TAB_W       = TAB_STOP_DEF;
  localparam int NCELLS      = COLS * NROWS;
  localparam int PHASE_ITEMS = 160;
  localparam int NPHASES     = 5;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 600;
  localparam int LIMIT       = 1000000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  req_t       req = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  rsp_t       rsp;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  // console model state
  logic [15:0] screen_model [NCELLS];
  int unsigned col_model;
  int unsigned row_model;
  logic [7:0]  attr_model;

  req_t        console_reqs [$];
  rsp_t        pending_rsps [$];
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          no_idle = 1'b0;
  logic        req_fire = 1'b0;

  text_console_char_writer dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  task automatic log_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    n_errors++;
  endtask

  function automatic void paint_cell(int unsigned c, logic [7:0] ch);
    if (c < COLS) begin
      screen_model[row_model * COLS + c] = {attr_model, ch};
    end
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < NCELLS; i++) begin
      screen_model[i] = (i + COLS < NCELLS) ? screen_model[i + COLS]
                                            : {attr_model, BLANK_CHAR};
    end
  endfunction

  // Advance the screen model by one transfer and return the response it gives.
  function automatic rsp_t next_console_rsp(req_t r);
    rsp_t        o;
    int unsigned stop;
    bit          line_adv;
    o = '0;
    line_adv = 1'b0;
    if (r.op == OP_READ) begin
      if (r.read_row < NROWS && r.read_col < COLS) begin
        o.cell_value = screen_model[r.read_row * COLS + r.read_col];
      end
    end else if (r.char_code != CH_NUL) begin
      case (r.char_code)
        CH_LF: begin
          col_model = 0;
          line_adv = 1'b1;
        end
        CH_CR: begin
          col_model = 0;
        end
        CH_TAB: begin
          stop = (col_model / TAB_W + 1) * TAB_W;
          while (col_model < stop) begin
            paint_cell(col_model, BLANK_CHAR);
            col_model++;
          end
        end
        CH_BS: begin
          if (col_model > 0) col_model--;
          paint_cell(col_model, BLANK_CHAR);
        end
        default: begin
          paint_cell(col_model, r.char_code);
          col_model++;
        end
      endcase
      if (col_model >= COLS) begin
        col_model = 0;
        line_adv = 1'b1;
      end
      if (line_adv) row_model++;
      if (row_model >= NROWS) begin
        scroll_screen();
        row_model = NROWS - 1;
      end
    end
    o.cursor_col = col_model[6:0];
    o.cursor_row = row_model[4:0];
    return o;
  endfunction

  task automatic push_req(logic op, logic [7:0] ch, logic [4:0] row, logic [6:0] col);
    req_t r;
    r.op = op;
    r.char_code = ch;
    r.read_row = row;
    r.read_col = col;
    console_reqs.push_back(r);
    n_queued++;
  endtask

  task automatic push_put(logic [7:0] ch);
    push_req(OP_PUT, ch, 5'($urandom), 7'($urandom));
  endtask

  task automatic write_attr(logic [7:0] v);
    @(negedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    attr_model = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (!(n_accepted == n_queued && pending_rsps.size() == 0)) @(negedge clk);
  endtask

  // Mostly well-formed console traffic, with some noise mixed in.
  task automatic queue_random_phase(int unsigned n);
    int unsigned start;
    int unsigned kind;
    int unsigned len;
    start = n_queued;
    while (n_queued - start < n) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        len = $urandom_range(90, 1);
        repeat (len) begin
          if ($urandom_range(9) == 0) push_put(8'($urandom_range(255, 1)));
          else push_put(8'($urandom_range(126, 32)));
        end
        if ($urandom_range(1)) push_put(CH_CR);
        if ($urandom_range(1)) push_put(CH_LF);
      end else if (kind < 52) begin
        repeat ($urandom_range(30, 1)) push_put(CH_LF);
      end else if (kind < 60) begin
        repeat ($urandom_range(12, 1)) push_put(CH_TAB);
      end else if (kind < 66) begin
        repeat ($urandom_range(6, 1)) push_put(CH_BS);
      end else if (kind < 70) begin
        push_put(CH_CR);
      end else if (kind < 85) begin
        repeat ($urandom_range(8, 1)) begin
          push_req(OP_READ, 8'($urandom), 5'($urandom_range(NROWS - 1)),
                   7'($urandom_range(COLS - 1)));
        end
      end else if (kind < 92) begin
        push_req(OP_READ, 8'($urandom), 5'($urandom), 7'($urandom));
      end else begin
        push_req(1'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
      end
    end
  endtask

  // accept side of the request channel: predict on every transfer
  always @(posedge clk) begin
    req_fire <= !rst && req_valid && !req_stall;
    if (!rst && req_valid && !req_stall) begin
      pending_rsps.push_back(next_console_rsp(req));
      n_accepted <= n_accepted + 1;
    end
  end

  // request driver: hold until transfer, then offer the next item or idle
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!(req_valid && !req_fire)) begin
      if (console_reqs.size() != 0 && (no_idle || $urandom_range(99) >= 13)) begin
        req_valid <= 1'b1;
        req <= console_reqs.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (hold_left != 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 13);
    end
  end

  // response monitor
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsps.size() == 0) begin
        log_mismatch($sformatf("response with none outstanding: %h", rsp));
      end else begin
        want = pending_rsps.pop_front();
        if (rsp.cell_value !== want.cell_value)
          log_mismatch($sformatf("cell_value want %h got %h", want.cell_value, rsp.cell_value));
        if (rsp.cursor_col !== want.cursor_col)
          log_mismatch($sformatf("cursor_col want %0d got %0d", want.cursor_col, rsp.cursor_col));
        if (rsp.cursor_row !== want.cursor_row)
          log_mismatch($sformatf("cursor_row want %0d got %0d", want.cursor_row, rsp.cursor_row));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("tb_text_console_char_writer: errors");
      $finish;
    end
  end

  initial begin
    logic [7:0] attr;
    for (int i = 0; i < NCELLS; i++) screen_model[i] = RESET_CELL;
    col_model = 0;
    row_model = 0;
    attr_model = ATTR_RESET;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // screen corners and reads past the edges
    push_req(OP_READ, 8'h00, 5'd0, 7'd0);
    push_req(OP_READ, 8'hFF, 5'(NROWS - 1), 7'(COLS - 1));
    push_req(OP_READ, 8'h00, 5'(NROWS), 7'd0);
    push_req(OP_READ, 8'h00, 5'd31, 7'd127);
    push_req(OP_READ, 8'h00, 5'd0, 7'(COLS));
    // printable extremes, NUL, then every control character
    push_put(8'h41);
    push_put(8'hFF);
    push_put(8'h01);
    push_put(CH_NUL);
    push_req(OP_READ, 8'h00, 5'd0, 7'd1);
    push_put(CH_TAB);
    push_put(CH_BS);
    push_put(CH_CR);
    push_put(CH_BS);
    push_put(CH_LF);
    push_put(8'h7E);
    push_req(OP_READ, 8'h00, 5'd1, 7'd0);
    push_req(OP_READ, 8'h00, 5'd0, 7'd7);
    wait_drained();

    for (int p = 0; p < NPHASES; p++) begin
      repeat (8) @(negedge clk);
      case (p)
        0: attr = 8'h00;
        1: attr = 8'hFF;
        2: attr = 8'hA5;
        3: attr = 8'($urandom_range(255));
        default: attr = 8'h5A;
      endcase
      write_attr(attr);
      no_idle = (p == 3);
      queue_random_phase(PHASE_ITEMS);
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (100) @(posedge clk);
    if (pending_rsps.size() != 0)
      log_mismatch($sformatf("%0d responses never arrived", pending_rsps.size()));
    if (n_errors == 0) begin
      $display("tb_text_console_char_writer: clean");
    end else begin
      $display("tb_text_console_char_writer: errors");
    end
    $finish;
  end

endmodule
